[src/strmm_pkg.sv]
package strmm_pkg;

  localparam int Depth     = 1024;
  localparam int Levels    = 11;
  localparam int DataWidth = 32;
  localparam int IdxW      = $clog2(Depth);
  localparam int CntW      = IdxW + 1;
  localparam int LvlW      = $clog2(Levels);

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_QUERY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
    logic [9:0]         range_start;
    logic [10:0]        range_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
    logic [31:0]        spread;
    logic [10:0]        element_count;
    logic [1:0]         status;
  } out_item_t;

  // token that runs down the chain of level cells
  typedef struct packed {
    logic                 app;     // append write wave
    logic                 qry;     // query read wave
    logic [IdxW-1:0]      pos;     // append: new index p
    logic [IdxW-1:0]      qa;      // query: left start
    logic [IdxW-1:0]      qb;      // query: right start
    logic [LvlW-1:0]      qlvl;    // query: level that answers
    logic [DataWidth-1:0] mx;      // offset binary max
    logic [DataWidth-1:0] mn;      // offset binary min
  } tok_t;

  // floor(log2(x)) via leading-one detect, clamped to the top level
  function automatic logic [LvlW-1:0] lead_one(input logic [CntW-1:0] x);
    logic [LvlW-1:0] k;
    k = '0;
    for (int i = 0; i < CntW; i++) begin
      if (x[i]) k = LvlW'(i);
    end
    if (k > LvlW'(Levels - 1)) k = LvlW'(Levels - 1);
    return k;
  endfunction

endpackage

[src/strmm_level_cell.sv]
module strmm_level_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [strmm_pkg::LvlW-1:0] level,
  input  strmm_pkg::tok_t            tok_in,
  output strmm_pkg::tok_t            tok_out
);
  import strmm_pkg::*;

  localparam int Words = Depth;

  // this level's table
  logic [DataWidth-1:0] mx_mem [Words];
  logic [DataWidth-1:0] mn_mem [Words];

  // a level-k entry at j combines the level k-1 entries at j and j + 2^(k-1);
  // the one at j + 2^(k-1) arrives with the token, the one at j comes from a
  // local copy of level k-1 that is filled from earlier tokens
  logic [DataWidth-1:0] sh_mx [Words];
  logic [DataWidth-1:0] sh_mn [Words];

  logic [IdxW-1:0]      half;
  logic [IdxW:0]        span;
  logic                 ok;
  logic [IdxW-1:0]      j;
  logic [IdxW-1:0]      jb;
  tok_t                 tok;
  logic [IdxW-1:0]      wr_j;
  logic                 wr_en;
  logic [DataWidth-1:0] rd_a_mx, rd_a_mn, rd_b_mx, rd_b_mn, rd_s_mx, rd_s_mn;
  logic [DataWidth-1:0] new_mx, new_mn;

  assign span = (IdxW + 1)'(1) << level;
  assign half = IdxW'(span >> 1);
  assign ok   = ({1'b0, tok_in.pos} + 1'b1) >= span;
  assign j    = tok_in.pos + 1'b1 - IdxW'(span);
  assign jb   = j + half;

  // token register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_in;
    end
  end

  // registered reads line up with the token register; own level is written from
  // the registered token, the copy of the previous level on arrival
  always_ff @(posedge clk) begin
    rd_a_mx <= mx_mem[tok_in.qa];
    rd_a_mn <= mn_mem[tok_in.qa];
    rd_b_mx <= mx_mem[tok_in.qb];
    rd_b_mn <= mn_mem[tok_in.qb];
    rd_s_mx <= sh_mx[j];
    rd_s_mn <= sh_mn[j];
    wr_j    <= j;
    wr_en   <= ok || (level == '0);
    if (tok_in.app && level != '0) begin
      sh_mx[jb] <= tok_in.mx;
      sh_mn[jb] <= tok_in.mn;
    end
    if (tok.app && wr_en) begin
      mx_mem[wr_j] <= new_mx;
      mn_mem[wr_j] <= new_mn;
    end
  end

  // level 0 takes the value, higher levels combine with the copy at j
  always_comb begin
    new_mx = tok.mx;
    new_mn = tok.mn;
    if (level != '0) begin
      new_mx = (rd_s_mx > tok.mx) ? rd_s_mx : tok.mx;
      new_mn = (rd_s_mn < tok.mn) ? rd_s_mn : tok.mn;
    end
  end

  // token handed to the next level
  always_comb begin
    tok_out = tok;
    if (tok.app) begin
      tok_out.mx = new_mx;
      tok_out.mn = new_mn;
      if (!wr_en) tok_out.app = 1'b0;
    end
    if (tok.qry && tok.qlvl == level) begin
      tok_out.mx = (rd_a_mx > rd_b_mx) ? rd_a_mx : rd_b_mx;
      tok_out.mn = (rd_a_mn < rd_b_mn) ? rd_a_mn : rd_b_mn;
    end
  end

endmodule

[src/sparse_table_range_min_max_unit.sv]
// Sparse-table range min/max unit. Each item returns one result. Appends to a
// table that is not full and legal queries pass a token through a chain of
// Levels cells (one per table level, each with its own memory); a clear, an
// unused code, an append when full or a bad query goes straight to the result.
// One item is in flight at a time. The tables need no clearing pass; a clear
// only resets the element count, as entries read by any legal query are rewritten first.
module sparse_table_range_min_max_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  strmm_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output strmm_pkg::out_item_t  out_data
);
  import strmm_pkg::*;

  localparam logic [DataWidth-1:0] SignBit = {1'b1, {(DataWidth-1){1'b0}}};

  state_t state, state_next;
  logic [CntW-1:0] count;
  logic [LvlW:0]   wait_cnt;
  out_item_t       res;
  out_item_t       res_next;
  tok_t            chain [Levels+1];
  tok_t            head;
  logic            go;
  logic [CntW-1:0] len;
  logic            bad;
  logic [LvlW-1:0] k;

  assign go  = in_valid && !in_stall;
  assign len = in_data.range_end - CntW'(in_data.range_start);
  assign bad = (CntW'(in_data.range_start) >= in_data.range_end) || (in_data.range_end > count);
  assign k   = lead_one(len);

  // token entering level 0
  always_comb begin
    head      = '0;
    head.pos  = IdxW'(count);
    head.mx   = in_data.value[DataWidth-1:0] ^ SignBit;
    head.mn   = in_data.value[DataWidth-1:0] ^ SignBit;
    head.qa   = IdxW'(in_data.range_start);
    head.qb   = IdxW'(in_data.range_end - (CntW'(1) << k));
    head.qlvl = k;
    if (go && state == ST_IDLE) begin
      head.app = (in_data.func == FUNC_APPEND) && (count < CntW'(Depth));
      head.qry = (in_data.func == FUNC_QUERY) && !bad;
    end
  end

  assign chain[0] = head;

  genvar g;
  generate
    for (g = 0; g < Levels; g++) begin : g_lvl
      strmm_level_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .level  (LvlW'(g)),
        .tok_in (chain[g]),
        .tok_out(chain[g+1])
      );
    end
  endgenerate

  // control
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE) || rst;
    out_valid  = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        if (go) begin
          if (head.app) state_next = ST_APPEND;
          else if (head.qry) state_next = ST_QUERY;
          else state_next = ST_OUT;
        end
      end
      ST_APPEND, ST_QUERY: begin
        if (wait_cnt == (LvlW+1)'(Levels)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) wait_cnt <= (LvlW+1)'(1);
      else wait_cnt <= wait_cnt + 1'b1;
      if (go) begin
        if (in_data.func == FUNC_CLEAR) count <= '0;
        else if (head.app) count <= count + 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    res_next = res;
    if (go) begin
      res_next = '0;
      if (in_data.func == FUNC_CLEAR) res_next.element_count = '0;
      else if (head.app) res_next.element_count = count + 1'b1;
      else res_next.element_count = count;
      if (in_data.func == FUNC_APPEND && !head.app) res_next.status = STAT_FULL;
      if (in_data.func == FUNC_QUERY && bad) res_next.status = STAT_BAD;
    end else if (state == ST_QUERY && wait_cnt == (LvlW+1)'(Levels)) begin
      res_next.max_value = chain[Levels].mx ^ SignBit;
      res_next.min_value = chain[Levels].mn ^ SignBit;
      res_next.spread    = chain[Levels].mx - chain[Levels].mn;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign out_data = res;

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("accepted while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule
